>>> hw/rtl/i2a_pkg.sv
// shared types and constants for the integer to ascii converter
// no dependencies; imported by i2a_front, i2a_back and the top level

package i2a_pkg;

   localparam int DEC_DIGITS = 20;
   localparam int DIGIT_IDX_W = $clog2(DEC_DIGITS);
   localparam int VALUE_W = 64;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_X = 8'h78;
   localparam logic [7:0] CHAR_A = 8'h61;

   typedef enum logic [1:0] {
      FUNC_DEC32 = 2'd0,
      FUNC_HEX32 = 2'd1,
      FUNC_DEC64 = 2'd2,
      FUNC_HEX64 = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0] func;
      logic [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic last;
   } rsp_payload_type;

   // classified job handed from front to back
   typedef struct packed {
      logic hex;
      logic wide;
      logic [VALUE_W-1:0] value;
   } job_type;

   typedef logic [DEC_DIGITS-1:0][3:0] digit_vec_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d >= 4'd10) begin
         c = CHAR_A + {4'd0, d} - 8'd10;
      end else begin
         c = CHAR_ZERO + {4'd0, d};
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/i2a_front.sv
// front end: accepts items, decodes the mode, masks the value and queues jobs
// depends on i2a_pkg

module i2a_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  i2a_pkg::req_payload_type req_data,
   output logic                     job_valid,
   output i2a_pkg::job_type         job,
   input  logic                     job_pop
);
   import i2a_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   job_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   job_type new_job;
   logic push;
   logic pop;

   // mode decode
   always_comb begin
      new_job.value = req_data.value;
      case (req_data.func) inside
         FUNC_HEX32, FUNC_HEX64: new_job.hex = 1'b1;
         default: new_job.hex = 1'b0;
      endcase
      case (req_data.func) inside
         FUNC_DEC64, FUNC_HEX64: new_job.wide = 1'b1;
         default: begin
            new_job.wide = 1'b0;
            new_job.value = {32'd0, req_data.value[31:0]};
         end
      endcase
   end

   assign req_ready = (count_ff != CNT_FULL);
   assign push = req_valid && req_ready;
   assign pop = job_pop && (count_ff != '0);
   assign job_valid = (count_ff != '0);
   assign job = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

>>> hw/rtl/i2a_back.sv
// back end: binary to bcd conversion, digit sizing and character output register
// depends on i2a_pkg

module i2a_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   input  i2a_pkg::job_type         job,
   output logic                     job_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output i2a_pkg::rsp_payload_type rsp_data
);
   import i2a_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CONV = 6'b000010,
      ST_SIZE = 6'b000100,
      ST_PFX0 = 6'b001000,
      ST_PFXX = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   function automatic logic [DEC_DIGITS*4-2:0] d_shift(input digit_vec_type v);
      logic [DEC_DIGITS*4-1:0] flat;
      flat = v;
      return flat[DEC_DIGITS*4-2:0];
   endfunction

   // eight shift-and-add-3 steps, one source byte msb first
   function automatic digit_vec_type dabble8(input digit_vec_type d, input logic [7:0] b);
      digit_vec_type v;
      v = d;
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < DEC_DIGITS; j++) begin
            if (v[j] >= 4'd5) begin
               v[j] = v[j] + 4'd3;
            end
         end
         v = digit_vec_type'({d_shift(v), b[7-i]});
      end
      return v;
   endfunction

   state_type state_ff, state_in;
   digit_vec_type digits_ff, digits_in;
   logic [VALUE_W-1:0] src_ff, src_in;
   logic [2:0] step_ff, step_in;
   logic hex_ff, hex_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [DIGIT_IDX_W-1:0] top_idx;
   logic out_free;

   // highest non-zero digit, zero when the value is zero
   always_comb begin
      top_idx = '0;
      for (int j = 0; j < DEC_DIGITS; j++) begin
         if (digits_ff[j] != 4'd0) begin
            top_idx = DIGIT_IDX_W'(j);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      digits_in = digits_ff;
      src_in = src_ff;
      step_in = step_ff;
      hex_in = hex_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      job_pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               hex_in = job.hex;
               step_in = job.wide ? 3'd7 : 3'd3;
               src_in = job.wide ? job.value : {job.value[31:0], 32'd0};
               if (job.hex) begin
                  digits_in = digit_vec_type'({16'd0, job.value});
                  state_in = ST_SIZE;
               end else begin
                  digits_in = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            digits_in = dabble8(digits_ff, src_ff[VALUE_W-1 -: 8]);
            src_in = {src_ff[VALUE_W-9:0], 8'd0};
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            idx_in = top_idx;
            state_in = hex_ff ? ST_PFX0 : ST_EMIT;
         end
         ST_PFX0: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.char_code = CHAR_ZERO;
               rsp_data_in.last = 1'b0;
               state_in = ST_PFXX;
            end
         end
         ST_PFXX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.char_code = CHAR_X;
               rsp_data_in.last = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.char_code = digit_char(digits_ff[idx_ff]);
               rsp_data_in.last = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      src_ff <= src_in;
      step_ff <= step_in;
      hex_ff <= hex_in;
      idx_ff <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

>>> hw/rtl/integer_to_ascii_converter.sv
// integer to ascii converter: top level joining the front end queue and the back end
// depends on i2a_pkg, i2a_front and i2a_back

// Each item carries a 64-bit unsigned value and a mode (decimal or hex, 32 or
// 64 bits); the block answers with one item per ascii character, most
// significant digit first, with last set on the final character. Decimal has
// no leading zeros and zero prints as "0"; hex is lower case with a "0x"
// prefix, leading zero nibbles dropped, and zero prints as "0x0". In the 32-bit
// modes bits 63..32 are ignored. The front end takes items into a small queue
// (QUEUE_DEPTH entries) so the input keeps flowing while the back end works.
// The back end handles one item at a time: it takes the item from the queue,
// then for decimal a shift-and-add-3 unit eats 8 value bits a cycle, a sizing
// step finds the leading digit, and then one character a cycle goes out through
// the output register while the receiver keeps up (hex skips the conversion
// unit and sends the "0x" prefix first). The character output and the
// conversion unit set the time per item.

module integer_to_ascii_converter #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  i2a_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output i2a_pkg::rsp_payload_type rsp_data
);
   import i2a_pkg::*;

   // classified job between front and back
   job_type job;
   logic job_valid;
   logic job_pop;

   // accept, decode mode, mask value, queue
   i2a_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .job_valid(job_valid),
      .job(job),
      .job_pop(job_pop)
   );

   // convert and emit characters
   i2a_back u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(job_valid),
      .job(job),
      .job_pop(job_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for integer_to_ascii_converter
// depends on i2a_pkg and the integer_to_ascii_converter rtl

module tb;

   import i2a_pkg::*;

   // hold-off length for the back-pressure test, and the settling time after
   // the last character
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_PERCENT = 26;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_data;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   // characters still to come, oldest first
   rsp_payload_type pending_chars[$];

   // idling switch and hold-off request, both written by the test tasks
   bit idle_enabled = 1'b1;
   int hold_ticket = 0;

   int mismatches = 0;
   int chars_checked = 0;
   int numbers_per_mode[4];

   integer_to_ascii_converter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // generous cap on the whole run
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

   // works out the character run of one number and queues it
   function automatic void queue_ascii_text(input func_type mode, input logic [63:0] number);
      logic [63:0] rest;
      logic [3:0] nibble;
      logic [7:0] text[$];
      bit wide;
      bit started;
      int top_nibble;
      rsp_payload_type ch;
      wide = (mode == FUNC_DEC64) || (mode == FUNC_HEX64);
      rest = wide ? number : {32'd0, number[31:0]};
      if (mode == FUNC_HEX32 || mode == FUNC_HEX64) begin
         text.push_back(CHAR_ZERO);
         text.push_back(CHAR_X);
         if (rest == 64'd0) begin
            text.push_back(CHAR_ZERO);
         end else begin
            started = 1'b0;
            top_nibble = wide ? 15 : 7;
            for (int i = top_nibble; i >= 0; i--) begin
               nibble = rest[i*4 +: 4];
               // leading zero nibbles are dropped
               if (nibble != 4'd0 || started) begin
                  started = 1'b1;
                  if (nibble >= 4'd10) begin
                     text.push_back(CHAR_A + 8'(nibble) - 8'd10);
                  end else begin
                     text.push_back(CHAR_ZERO + 8'(nibble));
                  end
               end
            end
         end
      end else begin
         if (rest == 64'd0) begin
            text.push_back(CHAR_ZERO);
         end
         // digits come out least significant first, so build from the front
         while (rest != 64'd0) begin
            text.push_front(CHAR_ZERO + 8'(rest % 64'd10));
            rest = rest / 64'd10;
         end
      end
      foreach (text[i]) begin
         ch.char_code = text[i];
         ch.last = (i == text.size() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   // random value with a random number of significant bits, so that every
   // run length turns up; the bits above 32 are often junk in 32-bit modes
   function automatic logic [63:0] random_number();
      logic [63:0] raw;
      int keep;
      raw = {$urandom, $urandom};
      keep = $urandom_range(0, 64);
      if ($urandom_range(15) == 0) begin
         raw = '1;
      end else if (keep < 64) begin
         raw = raw & ((64'd1 << keep) - 64'd1);
      end
      return raw;
   endfunction

   // offers one item and returns at the edge where it is taken
   task automatic send_number(input func_type mode, input logic [63:0] number);
      req_payload_type item;
      int gap;
      item.func = mode;
      item.value = number;
      gap = 0;
      if (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         gap = $urandom_range(1, 5);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      queue_ascii_text(mode, number);
      numbers_per_mode[mode]++;
   endtask

   // sender pauses until every character has come back
   task automatic wait_all_chars();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   // zero, extremes, hex letters, ignored upper bits and digit-count borders
   task automatic test_directed();
      send_number(FUNC_DEC32, 64'd0);
      send_number(FUNC_HEX32, 64'd0);
      send_number(FUNC_DEC64, 64'd0);
      send_number(FUNC_HEX64, 64'd0);
      send_number(FUNC_DEC32, 64'h0000_0000_FFFF_FFFF);
      send_number(FUNC_HEX32, 64'h0000_0000_FFFF_FFFF);
      send_number(FUNC_DEC64, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(FUNC_HEX64, 64'hFFFF_FFFF_FFFF_FFFF);
      // upper half set, lower half zero: both 32-bit modes must print zero
      send_number(FUNC_DEC32, 64'hFFFF_FFFF_0000_0000);
      send_number(FUNC_HEX32, 64'hFFFF_FFFF_0000_0000);
      send_number(FUNC_DEC32, 64'hDEAD_BEEF_0000_000A);
      send_number(FUNC_HEX32, 64'hDEAD_BEEF_0000_000A);
      send_number(FUNC_HEX64, 64'h0000_0000_00AB_CDEF);
      send_number(FUNC_HEX32, 64'h0000_0000_1234_5678);
      send_number(FUNC_DEC32, 64'd9);
      send_number(FUNC_DEC32, 64'd10);
      send_number(FUNC_DEC64, 64'd9_999_999_999);
      send_number(FUNC_DEC64, 64'd10_000_000_000);
      send_number(FUNC_HEX64, 64'h0000_0001_0000_0000);
      send_number(FUNC_HEX64, 64'd1);
      send_number(FUNC_HEX64, 64'h8000_0000_0000_0000);
      send_number(FUNC_DEC64, 64'd10_000_000_000_000_000_000);
      wait_all_chars();
   endtask

   // random modes and values with idling on both sides
   task automatic test_random_mix(input int count);
      repeat (count) send_number(func_type'($urandom_range(3)), random_number());
   endtask

   // a long stretch with no idling on either side
   task automatic test_back_to_back(input int count);
      idle_enabled <= 1'b0;
      repeat (count) send_number(func_type'($urandom_range(3)), random_number());
      idle_enabled <= 1'b1;
   endtask

   // the receiver holds off while items keep coming, so the queue fills and
   // the input stalls; then the sender waits for everything to drain
   task automatic test_back_pressure(input int count);
      hold_ticket <= hold_ticket + 1;
      repeat (count) send_number(func_type'($urandom_range(3)), random_number());
      wait_all_chars();
   endtask

   // receiver: drives ready and checks every character taken
   initial begin
      int served_ticket;
      int hold_left;
      rsp_payload_type want;
      served_ticket = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_chars.size() == 0) begin
               $error("character 0x%02h with no number waiting", rsp_data.char_code);
               mismatches++;
            end else begin
               want = pending_chars.pop_front();
               chars_checked++;
               if (rsp_data.char_code !== want.char_code) begin
                  $error("char_code: expected 0x%02h, got 0x%02h",
                         want.char_code, rsp_data.char_code);
                  mismatches++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  mismatches++;
               end
            end
         end
         // a new hold-off request starts its own count here
         if (hold_ticket != served_ticket) begin
            served_ticket = hold_ticket;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      req_valid <= 1'b0;
      req_data <= '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(120);
      test_back_to_back(40);
      test_back_pressure(30);
      test_random_mix(20);

      wait_all_chars();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d dec32, %0d hex32, %0d dec64 and %0d hex64 numbers",
               numbers_per_mode[FUNC_DEC32], numbers_per_mode[FUNC_HEX32],
               numbers_per_mode[FUNC_DEC64], numbers_per_mode[FUNC_HEX64]);
      $display("%0d characters compared, including a long output hold-off", chars_checked);
      if (mismatches == 0 && pending_chars.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
